/* rtl/core/segment_triangle_intersect_top_assert.svh */
// ----------------------------------------------------------------------------
// segment_triangle_intersect_top_assert
// assertion macros for the segment / triangle crossing test, clocked on clk
// and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TRIANGLE_INTERSECT_TOP_ASSERT_SVH
`define SEGMENT_TRIANGLE_INTERSECT_TOP_ASSERT_SVH

// same-cycle implication
`define STT_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// shared types and constants of the segment / triangle crossing test
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

	// width of one packed point on the ports
	localparam int FIELD_W = 60;

	// sign of one tetrahedron volume
	typedef struct packed {
		logic neg;
		logic zero;
	} vsign_t;

endpackage

`default_nettype wire

/* rtl/core/segment_triangle_intersect_top.sv */
// ----------------------------------------------------------------------------
// segment_triangle_intersect_top
// strict 3D segment / triangle crossing test from signed tetrahedron volumes
//
// channel  dir  handshake          payload
// command  in   start while !busy  seg_start, seg_end, tri_vertex_a/b/c
// result   out  done, one cycle    hit
//
// one beat accepted per cycle; busy is always low
// results pass through each volume pipeline, then the registered final decision
// eight volume pipelines run side by side, one per tetrahedron
// arst_n clears the valid pipeline only; data stages carry no reset
// the result side cannot stall, so nothing holds the pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module segment_triangle_intersect_top #(
	parameter int COORD_BITS = 20
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  [stt_pkg::FIELD_W-1:0]      seg_start,
	input  wire  [stt_pkg::FIELD_W-1:0]      seg_end,
	input  wire  [stt_pkg::FIELD_W-1:0]      tri_vertex_a,
	input  wire  [stt_pkg::FIELD_W-1:0]      tri_vertex_b,
	input  wire  [stt_pkg::FIELD_W-1:0]      tri_vertex_c,
	output logic                             hit,
	output logic                             done
);

	localparam int PT_W      = 3 * COORD_BITS;
	localparam int VOL_LAT   = 6;
	localparam int TOTAL_LAT = VOL_LAT + 1;

	// points: segment ends, then triangle corners
	localparam int P_IDX  [8] = '{2, 3, 3, 4, 4, 2, 0, 1};
	localparam int V0_IDX [8] = '{4, 4, 2, 2, 3, 3, 2, 2};
	localparam int V1_IDX [8] = '{0, 0, 0, 0, 0, 0, 3, 3};
	localparam int V2_IDX [8] = '{1, 1, 1, 1, 1, 1, 4, 4};

	logic [2:0][COORD_BITS-1:0] pt [5];
	stt_pkg::vsign_t [7:0]      sgn;
	logic [TOTAL_LAT-1:0]       vld_q;
	logic                       accept;
	logic                       on_plane;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// bits above the three coordinates are ignored
	assign pt[0] = PT_W'(seg_start);
	assign pt[1] = PT_W'(seg_end);
	assign pt[2] = PT_W'(tri_vertex_a);
	assign pt[3] = PT_W'(tri_vertex_b);
	assign pt[4] = PT_W'(tri_vertex_c);

	for (genvar g = 0; g < 8; g++) begin : g_vol
		stt_vol #(
			.CB (COORD_BITS)
		) u_vol (
			.clk (clk),
			.p   (pt[P_IDX[g]]),
			.v0  (pt[V0_IDX[g]]),
			.v1  (pt[V1_IDX[g]]),
			.v2  (pt[V2_IDX[g]]),
			.sgn (sgn[g])
		);
	end

	stt_decide u_decide (
		.clk (clk),
		.sgn (sgn),
		.hit (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], accept};
		end
	end

	assign done = vld_q[TOTAL_LAT-1];

	// an endpoint on the triangle's plane
	assign on_plane = sgn[6].zero || sgn[7].zero;

`include "segment_triangle_intersect_top_assert.svh"

	`STT_ASSERT_IMPLY(a_done_from_beat, done, $past(accept, TOTAL_LAT), "result without a beat")
	`STT_ASSERT_NEXT(a_plane_touch_miss, vld_q[VOL_LAT-1] && on_plane, done && !hit, "hit on plane")

endmodule

`default_nettype wire

/* rtl/core/stt_vol.sv */
// ----------------------------------------------------------------------------
// stt_vol
// six-stage pipeline giving the exact sign of the tetrahedron volume
// (v0 - v1) . ((v1 - p) x (v2 - p))
// ----------------------------------------------------------------------------
`default_nettype none

module stt_vol #(
	parameter int CB = 20
) (
	input  wire                    clk,
	input  wire  [2:0][CB-1:0]     p,
	input  wire  [2:0][CB-1:0]     v0,
	input  wire  [2:0][CB-1:0]     v1,
	input  wire  [2:0][CB-1:0]     v2,
	output stt_pkg::vsign_t        sgn
);

	localparam int DW   = CB + 1;        // difference
	localparam int PW   = 2 * DW;        // cross partial product
	localparam int XW   = PW + 1;        // cross component
	localparam int LO_W = XW - DW;       // low slice of a cross component
	localparam int LW   = DW + LO_W + 1; // low dot partial product
	localparam int TW   = DW + XW;       // dot term
	localparam int SW   = TW + 2;        // dot sum

	logic signed [DW-1:0] d1_s1 [3];
	logic signed [DW-1:0] d2_s1 [3];
	logic signed [DW-1:0] d3_s1 [3];
	logic signed [DW-1:0] d1_s2 [3];
	logic signed [PW-1:0] ma_s2 [3];
	logic signed [PW-1:0] mb_s2 [3];
	logic signed [DW-1:0] d1_s3 [3];
	logic signed [XW-1:0] cr_s3 [3];
	logic signed [LW-1:0] plo_s4 [3];
	logic signed [PW-1:0] phi_s4 [3];
	logic signed [TW-1:0] term_s5 [3];
	logic signed [SW-1:0] sum;
	stt_pkg::vsign_t      sgn_s6;

	// s1: differences
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			d1_s1[k] <= DW'($signed(v0[k])) - DW'($signed(v1[k]));
			d2_s1[k] <= DW'($signed(v1[k])) - DW'($signed(p[k]));
			d3_s1[k] <= DW'($signed(v2[k])) - DW'($signed(p[k]));
		end
	end

	// s2: six cross partial products
	always_ff @(posedge clk) begin
		d1_s2    <= d1_s1;
		ma_s2[0] <= PW'(d2_s1[1]) * PW'(d3_s1[2]);
		mb_s2[0] <= PW'(d2_s1[2]) * PW'(d3_s1[1]);
		ma_s2[1] <= PW'(d2_s1[2]) * PW'(d3_s1[0]);
		mb_s2[1] <= PW'(d2_s1[0]) * PW'(d3_s1[2]);
		ma_s2[2] <= PW'(d2_s1[0]) * PW'(d3_s1[1]);
		mb_s2[2] <= PW'(d2_s1[1]) * PW'(d3_s1[0]);
	end

	// s3: cross components
	always_ff @(posedge clk) begin
		d1_s3 <= d1_s2;
		for (int k = 0; k < 3; k++) begin
			cr_s3[k] <= XW'(ma_s2[k]) - XW'(mb_s2[k]);
		end
	end

	// s4: dot products split into a signed high slice and an unsigned low slice
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			plo_s4[k] <= LW'(d1_s3[k]) * LW'($signed({1'b0, cr_s3[k][LO_W-1:0]}));
			phi_s4[k] <= PW'(d1_s3[k]) * PW'($signed(cr_s3[k][XW-1:LO_W]));
		end
	end

	// s5: recombine each term
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			term_s5[k] <= (TW'(phi_s4[k]) <<< LO_W) + TW'(plo_s4[k]);
		end
	end

	// s6: sum and sign
	assign sum = SW'(term_s5[0]) + SW'(term_s5[1]) + SW'(term_s5[2]);

	always_ff @(posedge clk) begin
		sgn_s6.neg  <= sum[SW-1];
		sgn_s6.zero <= (sum == '0);
	end

	assign sgn = sgn_s6;

endmodule

`default_nettype wire

/* rtl/core/stt_decide.sv */
// ----------------------------------------------------------------------------
// stt_decide
// combines the edge signs and the plane signs into the hit flag
// ----------------------------------------------------------------------------
`default_nettype none

module stt_decide (
	input  wire                        clk,
	input  stt_pkg::vsign_t [7:0]      sgn,
	output logic                       hit
);

	logic reject;
	logic straddle;
	logic hit_s7;

	function automatic logic same_strict(stt_pkg::vsign_t a, stt_pkg::vsign_t b);
		return !a.zero && !b.zero && (a.neg == b.neg);
	endfunction

	// edge tests come in pairs, the plane test is the last pair
	assign reject = same_strict(sgn[0], sgn[1]) || same_strict(sgn[2], sgn[3])
		|| same_strict(sgn[4], sgn[5]);
	assign straddle = !sgn[6].zero && !sgn[7].zero && (sgn[6].neg != sgn[7].neg);

	always_ff @(posedge clk) begin
		hit_s7 <= !reject && straddle;
	end

	assign hit = hit_s7;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the segment / triangle crossing test: a queue-fed
// driver issues directed and random beats with random gaps, a predictor
// computes the exact volume signs and the monitor checks every hit in order
// ----------------------------------------------------------------------------

module tb_top;

	localparam int FIELD_W     = stt_pkg::FIELD_W;
	localparam int CB          = 20;
	localparam int MAXP        = (1 << (CB - 1)) - 1;
	localparam int MAXN        = -(1 << (CB - 1));
	localparam int HALF        = (1 << (CB - 2)) - 1;
	localparam int N_RANDOM    = 930;
	localparam int STALL_LIMIT = 500;
	localparam int DRAIN_WAIT  = 12;

	typedef struct {
		logic [FIELD_W-1:0] s0, s1, ta, tb, tc;
		int unsigned        gap;
		bit                 drain;
	} cmd_t;

	typedef struct {
		bit          hit;
		int unsigned beat;
	} hit_exp_t;

	typedef struct {
		longint x, y, z;
	} vec_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [FIELD_W-1:0] seg_start = '0;
	logic [FIELD_W-1:0] seg_end = '0;
	logic [FIELD_W-1:0] tri_vertex_a = '0;
	logic [FIELD_W-1:0] tri_vertex_b = '0;
	logic [FIELD_W-1:0] tri_vertex_c = '0;
	logic               busy;
	logic               hit;
	logic               done;

	cmd_t        pend_q[$];
	hit_exp_t    hit_q[$];
	int unsigned gap_cnt = 0;
	int unsigned beat_cnt = 0;
	int unsigned stall_cnt = 0;
	int unsigned errors = 0;

	segment_triangle_intersect_top #(
		.COORD_BITS(CB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.seg_start(seg_start),
		.seg_end(seg_end),
		.tri_vertex_a(tri_vertex_a),
		.tri_vertex_b(tri_vertex_b),
		.tri_vertex_c(tri_vertex_c),
		.hit(hit),
		.done(done)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic vec_t unpack_point(logic [FIELD_W-1:0] w);
		vec_t v;
		v.x = longint'($signed(w[0*CB +: CB]));
		v.y = longint'($signed(w[1*CB +: CB]));
		v.z = longint'($signed(w[2*CB +: CB]));
		return v;
	endfunction

	// sign of six times the volume of tetrahedron (p, v0, v1, v2), exact
	function automatic stt_pkg::vsign_t volume_sign(vec_t p, vec_t v0, vec_t v1, vec_t v2);
		vec_t                d1, d2, d3;
		longint              cx, cy, cz;
		logic signed [127:0] ax, ay, az, bx, by, bz, acc;
		stt_pkg::vsign_t     s;
		d1.x = v0.x - v1.x;  d1.y = v0.y - v1.y;  d1.z = v0.z - v1.z;
		d2.x = v1.x - p.x;   d2.y = v1.y - p.y;   d2.z = v1.z - p.z;
		d3.x = v2.x - p.x;   d3.y = v2.y - p.y;   d3.z = v2.z - p.z;
		cx = d2.y * d3.z - d2.z * d3.y;
		cy = d2.z * d3.x - d2.x * d3.z;
		cz = d2.x * d3.y - d2.y * d3.x;
		ax = d1.x;  ay = d1.y;  az = d1.z;
		bx = cx;    by = cy;    bz = cz;
		acc = ax * bx + ay * by + az * bz;
		s.neg  = acc[127];
		s.zero = (acc == 0);
		return s;
	endfunction

	function automatic bit strict_same(stt_pkg::vsign_t a, stt_pkg::vsign_t b);
		return !a.zero && !b.zero && (a.neg == b.neg);
	endfunction

	function automatic bit crossing_hit(logic [FIELD_W-1:0] w0, logic [FIELD_W-1:0] w1,
			logic [FIELD_W-1:0] wa, logic [FIELD_W-1:0] wb, logic [FIELD_W-1:0] wc);
		vec_t            l0, l1, t0, t1, t2;
		bit              reject;
		stt_pkg::vsign_t s0, s1;
		l0 = unpack_point(w0);
		l1 = unpack_point(w1);
		t0 = unpack_point(wa);
		t1 = unpack_point(wb);
		t2 = unpack_point(wc);
		// edge tests: both volumes strictly on one side means the line misses
		reject = strict_same(volume_sign(t0, t2, l0, l1), volume_sign(t1, t2, l0, l1))
			|| strict_same(volume_sign(t1, t0, l0, l1), volume_sign(t2, t0, l0, l1))
			|| strict_same(volume_sign(t2, t1, l0, l1), volume_sign(t0, t1, l0, l1));
		s0 = volume_sign(l0, t0, t1, t2);
		s1 = volume_sign(l1, t0, t1, t2);
		return !reject && !s0.zero && !s1.zero && (s0.neg != s1.neg);
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic logic [FIELD_W-1:0] pk(int x, int y, int z);
		return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
	endfunction

	function automatic int rnd_coord(int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	function automatic int extreme_coord();
		case ($urandom_range(0, 5))
			0: return MAXP;
			1: return MAXN;
			2: return 0;
			3: return -1;
			4: return 1;
			default: return MAXN + 1;
		endcase
	endfunction

	function automatic logic [FIELD_W-1:0] rnd_bits();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[FIELD_W-1:0];
	endfunction

	task automatic push_item(logic [FIELD_W-1:0] s0, logic [FIELD_W-1:0] s1,
			logic [FIELD_W-1:0] ta, logic [FIELD_W-1:0] tb, logic [FIELD_W-1:0] tc,
			int unsigned gap, bit drain);
		cmd_t c;
		c.s0 = s0;  c.s1 = s1;  c.ta = ta;  c.tb = tb;  c.tc = tc;
		c.gap = gap;
		c.drain = drain;
		pend_q.push_back(c);
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		logic launch;
		cmd_t nxt;
		hit_exp_t e;
		if (arst_n) begin
			launch = start;
			if (start && !busy) begin
				e.hit  = crossing_hit(seg_start, seg_end, tri_vertex_a, tri_vertex_b,
					tri_vertex_c);
				e.beat = beat_cnt;
				hit_q.push_back(e);
				beat_cnt++;
				launch = 1'b0;
			end
			if (!launch && pend_q.size() != 0) begin
				if (gap_cnt < pend_q[0].gap) begin
					gap_cnt++;
				end else if (!(pend_q[0].drain && hit_q.size() != 0)) begin
					nxt = pend_q.pop_front();
					seg_start    <= nxt.s0;
					seg_end      <= nxt.s1;
					tri_vertex_a <= nxt.ta;
					tri_vertex_b <= nxt.tb;
					tri_vertex_c <= nxt.tc;
					launch = 1'b1;
					gap_cnt = 0;
				end
			end
			start <= launch;
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		hit_exp_t e;
		if (arst_n && done) begin
			if (hit_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none actual hit=%b", $time, hit);
			end else begin
				e = hit_q.pop_front();
				if (hit !== e.hit) begin
					errors++;
					$display("%0t beat %0d hit mismatch: expected %b actual %b",
						$time, e.beat, e.hit, hit);
				end
			end
		end
	end

	// nothing accepted on either side for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("%0t watchdog: no beat for %0d cycles", $time, stall_cnt);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int a[3], b[3], c[3], m[3], d[3];
		int lim, w0, w1, w2, wsum, kind;
		int unsigned gap;
		bit drain;

		// directed corners
		push_item('0, '0, '0, '0, '0, 0, 0);
		push_item('1, '1, '1, '1, '1, 0, 0);
		push_item(pk(10, 10, -50), pk(10, 10, 50), pk(0, 0, 0), pk(100, 0, 0),
			pk(0, 100, 0), 0, 0);
		push_item(pk(10, 10, 50), pk(10, 10, -50), pk(0, 0, 0), pk(100, 0, 0),
			pk(0, 100, 0), 3, 0);
		// line passes beside the triangle
		push_item(pk(200, 200, -50), pk(200, 200, 50), pk(0, 0, 0), pk(100, 0, 0),
			pk(0, 100, 0), 0, 0);
		// endpoint lies on the plane
		push_item(pk(10, 10, 0), pk(10, 10, 50), pk(0, 0, 0), pk(100, 0, 0),
			pk(0, 100, 0), 1, 0);
		// both endpoints on one side
		push_item(pk(10, 10, 5), pk(10, 10, 50), pk(0, 0, 0), pk(100, 0, 0),
			pk(0, 100, 0), 0, 0);
		// through a vertex and through an edge: zero edge volumes
		push_item(pk(0, 0, -5), pk(0, 0, 5), pk(0, 0, 0), pk(100, 0, 0),
			pk(0, 100, 0), 0, 0);
		push_item(pk(50, 0, -5), pk(50, 0, 5), pk(0, 0, 0), pk(100, 0, 0),
			pk(0, 100, 0), 14, 0);
		// degenerate triangle and degenerate segment
		push_item(pk(1, 1, -5), pk(1, 1, 5), pk(0, 0, 0), pk(1, 1, 1),
			pk(2, 2, 2), 0, 0);
		push_item(pk(10, 10, 0), pk(10, 10, 0), pk(0, 0, 0), pk(100, 0, 0),
			pk(0, 100, 0), 0, 0);
		// segment lying in the plane
		push_item(pk(-10, 20, 0), pk(120, 20, 0), pk(0, 0, 0), pk(100, 0, 0),
			pk(0, 100, 0), 0, 0);
		// full-range coordinates drive the products to their widest
		push_item(pk(0, 0, MAXN), pk(-1, -1, MAXP), pk(MAXN, MAXN, 0),
			pk(MAXP, MAXN, 0), pk(MAXN, MAXP, 0), 0, 0);
		push_item(pk(-1, -1, MAXP), pk(0, 0, MAXN), pk(MAXN, MAXN, 0),
			pk(MAXP, MAXN, 0), pk(MAXN, MAXP, 0), 0, 0);
		push_item(pk(MAXP, MAXN, MAXP), pk(MAXN, MAXP, MAXN), pk(MAXP, MAXP, MAXN),
			pk(MAXN, MAXN, MAXN), pk(MAXN, MAXP, MAXP), 2, 0);
		push_item(pk(MAXN, MAXN, MAXN), pk(MAXP, MAXP, MAXP), pk(MAXP, MAXN, MAXN),
			pk(MAXN, MAXP, MAXN), pk(MAXN, MAXN, MAXP), 0, 0);
		push_item({15{4'h5}}, {15{4'hA}}, {15{4'hA}}, {15{4'h5}}, {15{4'h3}}, 0, 0);
		push_item({15{4'hA}}, {15{4'h5}}, {15{4'hC}}, {15{4'h3}}, {15{4'h5}}, 0, 1);
		push_item(pk(HALF, -HALF, -7), pk(-HALF, HALF, 7), pk(MAXN, 0, 0),
			pk(MAXP, MAXN, 0), pk(0, MAXP, 0), 5, 0);

		for (int i = 0; i < N_RANDOM; i++) begin
			// every third stretch of 64 beats runs without gaps
			gap = ((i / 64) % 3 == 0) ? 0 : $urandom_range(0, 14);
			drain = (i % 97 == 50);
			kind = $urandom_range(0, 19);
			case ($urandom_range(0, 2))
				0: lim = 4;
				1: lim = 1000;
				default: lim = HALF;
			endcase
			if (kind < 12) begin
				// well-formed: segment through a point of the triangle, rounded to the grid
				for (int k = 0; k < 3; k++) begin
					a[k] = rnd_coord(lim);
					b[k] = rnd_coord(lim);
					c[k] = rnd_coord(lim);
				end
				w0 = $urandom_range(0, 7);
				w1 = $urandom_range(0, 7);
				w2 = $urandom_range(0, 7);
				wsum = w0 + w1 + w2;
				if (wsum == 0) begin
					w0 = 1;
					wsum = 1;
				end
				for (int k = 0; k < 3; k++) begin
					m[k] = (w0 * a[k] + w1 * b[k] + w2 * c[k]) / wsum;
					d[k] = rnd_coord(lim);
				end
				if ($urandom_range(0, 7) == 0)
					push_item(pk(m[0], m[1], m[2]),
						pk(m[0] + d[0], m[1] + d[1], m[2] + d[2]),
						pk(a[0], a[1], a[2]), pk(b[0], b[1], b[2]), pk(c[0], c[1], c[2]),
						gap, drain);
				else
					push_item(pk(m[0] - d[0], m[1] - d[1], m[2] - d[2]),
						pk(m[0] + d[0], m[1] + d[1], m[2] + d[2]),
						pk(a[0], a[1], a[2]), pk(b[0], b[1], b[2]), pk(c[0], c[1], c[2]),
						gap, drain);
			end else if (kind < 15) begin
				push_item(rnd_bits(), rnd_bits(), rnd_bits(), rnd_bits(), rnd_bits(),
					gap, drain);
			end else if (kind < 18) begin
				push_item(pk(rnd_coord(lim), rnd_coord(lim), rnd_coord(lim)),
					pk(rnd_coord(lim), rnd_coord(lim), rnd_coord(lim)),
					pk(rnd_coord(lim), rnd_coord(lim), rnd_coord(lim)),
					pk(rnd_coord(lim), rnd_coord(lim), rnd_coord(lim)),
					pk(rnd_coord(lim), rnd_coord(lim), rnd_coord(lim)), gap, drain);
			end else begin
				push_item(pk(extreme_coord(), extreme_coord(), extreme_coord()),
					pk(extreme_coord(), extreme_coord(), extreme_coord()),
					pk(extreme_coord(), extreme_coord(), extreme_coord()),
					pk(extreme_coord(), extreme_coord(), extreme_coord()),
					pk(extreme_coord(), extreme_coord(), extreme_coord()), gap, drain);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pend_q.size() != 0 || start || hit_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/stt_pkg.sv
rtl/core/stt_vol.sv
rtl/core/stt_decide.sv
rtl/core/segment_triangle_intersect_top.sv
sim/tb_top.sv
